@@ sv/gtbp_pkg.sv @@
// Shared types, codes and counter helpers for the gshare/local tournament predictor.
// No dependencies; imported by the predictor top level.
package gtbp_pkg;

   // 2-bit saturating counter
   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_MAX  = 2'd3;
   localparam ctr_type CTR_INIT = 2'd1;

   // Predictor kinds held in the kind register
   typedef enum logic [1:0] {
      KIND_STATIC     = 2'd0,
      KIND_GSHARE     = 2'd1,
      KIND_TOURNAMENT = 2'd2,
      KIND_NONE       = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_KIND        = 2'd0,
      CSR_GLOBAL_BITS = 2'd1,
      CSR_LOCAL_BITS  = 2'd2,
      CSR_PC_BITS     = 2'd3
   } csr_index_type;

   // Register reset values
   localparam kind_type   RST_KIND        = KIND_GSHARE;
   localparam logic [3:0] RST_GLOBAL_BITS = 4'd13;
   localparam logic [3:0] RST_LOCAL_BITS  = 4'd10;
   localparam logic [3:0] RST_PC_BITS     = 4'd10;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LREAD,
      ST_DECIDE
   } state_type;

   // Saturating step of a 2-bit counter towards taken (up) or not taken
   function automatic ctr_type ctr_bump(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 2'd1;
      end else begin
         if (c != 2'd0) r = c - 2'd1;
      end
      return r;
   endfunction

endpackage

@@ sv/gshare_tournament_branch_predictor.sv @@
// Tournament branch predictor: gshare and local-history components with a chooser.
// Depends on gtbp_pkg for counter types, kind and register codes, and states.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_ready | req_mode, req_pc, req_outcome
//   rsp     | out       | rsp_valid / rsp_ready | rsp_taken_guess
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// The response register loads as the decide state commits, after the idle state accepts
// a request and the local-read state follows; a new request is taken only after the last
// is written back: the local history read must return before the local counter read can
// be issued, and the write-back follows in the decide state. After reset a clearing pass
// steps a counter of max(GLOBAL_BITS_MAX, LOCAL_BITS_MAX, PC_BITS_MAX) bits and writes
// every table entry; req_ready stays low meanwhile. A response waiting on rsp_ready holds
// the next request in its decide cycle. csr writes are always accepted.
module gshare_tournament_branch_predictor
   import gtbp_pkg::*;
#(
   parameter int GLOBAL_BITS_MAX = 13,
   parameter int LOCAL_BITS_MAX  = 11,
   parameter int PC_BITS_MAX     = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_pc,
   input  logic        req_outcome,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_taken_guess,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   localparam int G        = GLOBAL_BITS_MAX;
   localparam int L        = LOCAL_BITS_MAX;
   localparam int P        = PC_BITS_MAX;
   localparam int GL_MAX   = (G > L) ? G : L;
   localparam int CLR_BITS = (GL_MAX > P) ? GL_MAX : P;
   localparam int G_DEPTH  = 1 << G;
   localparam int L_DEPTH  = 1 << L;
   localparam int P_DEPTH  = 1 << P;

   // Table storage
   ctr_type        gshare_mem  [G_DEPTH];
   ctr_type        chooser_mem [G_DEPTH];
   logic [L-1:0]   lhist_mem   [P_DEPTH];
   ctr_type        lctr_mem    [L_DEPTH];

   // Control and configuration registers
   state_type      state_ff, state_in;
   logic [CLR_BITS-1:0] clr_ff, clr_in;
   kind_type       kind_ff;
   logic [3:0]     gbits_ff, lbits_ff, pbits_ff;
   logic [G-1:0]   ghist_ff, ghist_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_guess_ff, rsp_guess_in;

   // Per-request registers
   logic           mode_ff, outcome_ff;
   logic [G-1:0]   gidx_ff, cidx_ff;
   logic [P-1:0]   pidx_ff;
   logic [L-1:0]   lhist_ff;

   // Memory read data
   ctr_type        gs_rd_ff, ch_rd_ff, lc_rd_ff;
   logic [L-1:0]   lh_rd_ff;

   // Sequencer outputs
   logic           clearing, rd_issue, lc_re, commit, out_free;

   // Combinational indexes and masks
   logic [G-1:0]   gmask, gidx_in, cidx_in;
   logic [L-1:0]   lmask, lhist_in;
   logic [P-1:0]   pmask, pidx_in;

   // Prediction and write-back values
   logic           g_pred, l_pred, use_local, guess;
   logic           train_g, train_t;
   logic           gs_we, ch_we, lh_we, lc_we;
   logic [G-1:0]   gs_waddr, ch_waddr;
   logic [P-1:0]   lh_waddr;
   logic [L-1:0]   lc_waddr;
   ctr_type        gs_wdata, ch_wdata, lc_wdata;
   logic [L-1:0]   lh_wdata;

   // Build the width masks; widths above the maximum saturate naturally
   always_comb begin
      for (int i = 0; i < G; i++) gmask[i] = (5'(i) < {1'b0, gbits_ff});
      for (int i = 0; i < L; i++) lmask[i] = (5'(i) < {1'b0, lbits_ff});
      for (int i = 0; i < P; i++) pmask[i] = (5'(i) < {1'b0, pbits_ff});
   end

   // Form the table indexes
   assign gidx_in  = (req_pc[G-1:0] ^ ghist_ff) & gmask;
   assign cidx_in  = ghist_ff & gmask;
   assign pidx_in  = req_pc[P-1:0] & pmask;
   assign lhist_in = lh_rd_ff & lmask;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_LREAD;
         ST_LREAD:  state_in = ST_DECIDE;
         ST_DECIDE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      clearing  = 1'b0;
      req_ready = 1'b0;
      rd_issue  = 1'b0;
      lc_re     = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  clearing = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_issue  = req_valid;
         end
         ST_LREAD:  lc_re = 1'b1;
         ST_DECIDE: commit = out_free;
         default:   clearing = 1'b0;
      endcase
   end

   // Pick the direction from the components
   assign g_pred    = gs_rd_ff[1];
   assign l_pred    = lc_rd_ff[1];
   assign use_local = ch_rd_ff[1];

   always_comb begin
      case (kind_ff)
         KIND_STATIC:     guess = 1'b1;
         KIND_GSHARE:     guess = g_pred;
         KIND_TOURNAMENT: guess = use_local ? l_pred : g_pred;
         default:         guess = 1'b0;
      endcase
   end

   assign train_g = mode_ff && (kind_ff == KIND_GSHARE || kind_ff == KIND_TOURNAMENT);
   assign train_t = mode_ff && (kind_ff == KIND_TOURNAMENT);

   // Write-back: clearing pass or trained values
   always_comb begin
      gs_we    = clearing || (commit && train_g);
      ch_we    = clearing || (commit && train_t && (l_pred != g_pred));
      lh_we    = clearing || (commit && train_t);
      lc_we    = clearing || (commit && train_t);
      gs_waddr = clearing ? clr_ff[G-1:0] : gidx_ff;
      ch_waddr = clearing ? clr_ff[G-1:0] : cidx_ff;
      lh_waddr = clearing ? clr_ff[P-1:0] : pidx_ff;
      lc_waddr = clearing ? clr_ff[L-1:0] : lhist_ff;
      gs_wdata = clearing ? CTR_INIT : ctr_bump(gs_rd_ff, outcome_ff);
      ch_wdata = clearing ? CTR_INIT : ctr_bump(ch_rd_ff, l_pred == outcome_ff);
      lc_wdata = clearing ? CTR_INIT : ctr_bump(lc_rd_ff, outcome_ff);
      lh_wdata = clearing ? '0 : (((lhist_ff << 1) | L'(outcome_ff)) & lmask);
   end

   // Gshare and chooser tables
   always_ff @(posedge clock) begin
      if (gs_we) gshare_mem[gs_waddr] <= gs_wdata;
      if (rd_issue) gs_rd_ff <= gshare_mem[gidx_in];
   end

   always_ff @(posedge clock) begin
      if (ch_we) chooser_mem[ch_waddr] <= ch_wdata;
      if (rd_issue) ch_rd_ff <= chooser_mem[cidx_in];
   end

   // Local history and local counter tables
   always_ff @(posedge clock) begin
      if (lh_we) lhist_mem[lh_waddr] <= lh_wdata;
      if (rd_issue) lh_rd_ff <= lhist_mem[pidx_in];
   end

   always_ff @(posedge clock) begin
      if (lc_we) lctr_mem[lc_waddr] <= lc_wdata;
      if (lc_re) lc_rd_ff <= lctr_mem[lhist_in];
   end

   // Hold the request fields and indexes
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         mode_ff    <= req_mode;
         outcome_ff <= req_outcome;
         gidx_ff    <= gidx_in;
         cidx_ff    <= cidx_in;
         pidx_ff    <= pidx_in;
      end
      if (lc_re) lhist_ff <= lhist_in;
   end

   // Advance the clear counter and the global history
   assign clr_in   = clearing ? clr_ff + CLR_BITS'(1) : clr_ff;
   assign ghist_in = (commit && train_g) ? ((ghist_ff << 1) | G'(outcome_ff)) : ghist_ff;

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_guess_in = rsp_guess_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_guess_in = guess;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ghist_ff     <= ghist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_guess_ff <= rsp_guess_in;
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= RST_KIND;
         gbits_ff <= RST_GLOBAL_BITS;
         lbits_ff <= RST_LOCAL_BITS;
         pbits_ff <= RST_PC_BITS;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_KIND:        kind_ff  <= kind_type'(csr_data[1:0]);
            CSR_GLOBAL_BITS: gbits_ff <= csr_data;
            CSR_LOCAL_BITS:  lbits_ff <= csr_data;
            CSR_PC_BITS:     pbits_ff <= csr_data;
            default:         kind_ff  <= kind_ff;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taken_guess = rsp_guess_ff;

endmodule

@@ sv/gtbp_checker.sv @@
// Port-level checker for the tournament branch predictor, bound to its top level.
// Depends only on the top level's ports; no package import needed.
module gtbp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_taken_guess
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Track requests whose response has not yet been taken
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) pending_in = pending_ff + 2'd1;
      else if (!req_fire && rsp_fire) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pending_ff <= '0;
      else pending_ff <= pending_in;
   end

   // A held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_taken_guess))
      else $error("response changed while stalled");

   // No response without an outstanding request, and at most two in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || pending_ff != 2'd0) && pending_ff != 2'd3)
      else $error("response count does not match requests");

   // One request at a time: the next is not taken in the following cycle
   a_sequential: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken back to back");

   // Reset starts the clearing pass with nothing pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind gshare_tournament_branch_predictor gtbp_checker u_gtbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_taken_guess (rsp_taken_guess)
);
